### src/mbt_pkg.sv
// Shared types, constants and fixed-point helpers of the MLP training core.
// Used by every module of the block but mbt_fifo; depends on nothing.
package mbt_pkg;

    localparam int DW        = 32;
    localparam int NEUR_W    = 4;
    localparam int LAYER_W   = 2;
    localparam int CNT_W     = 5;
    localparam int MAX_NEUR  = 16;
    localparam int MAX_LAYER = 4;

    localparam logic signed [DW-1:0] MAXV  = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] MINV  = 32'sh8000_0000;
    localparam logic signed [DW-1:0] ONEV  = 32'sd65536;
    localparam logic signed [DW-1:0] LEAKV = 32'sd655;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;
    localparam logic [1:0] OP_TARGET = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic                 step;
        logic [LAYER_W-1:0]   layer;
        logic [NEUR_W-1:0]    neuron;
        logic [NEUR_W-1:0]    windex;
        logic signed [DW-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic [15:0]                learning_rate;
        logic [CNT_W-1:0]           input_count;
        logic [2:0]                 layer_count;
        logic [3:0][CNT_W-1:0]      layer_size;
    } t_cfg;

    typedef struct packed {
        logic [NEUR_W-1:0]    neuron;
        logic signed [DW-1:0] value;
        logic                 last;
        logic                 sat;
    } t_res;

    typedef struct packed {
        logic                 sat;
        logic signed [DW-1:0] val;
    } t_sres;

    function automatic t_sres sat33(input logic signed [DW:0] s);
        t_sres r;
        if (s[DW] != s[DW-1]) begin
            r.sat = 1'b1;
            r.val = s[DW] ? MINV : MAXV;
        end else begin
            r.sat = 1'b0;
            r.val = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_sres sadd(input logic signed [DW-1:0] a,
                                   input logic signed [DW-1:0] b);
        return sat33({a[DW-1], a} + {b[DW-1], b});
    endfunction

    function automatic t_sres ssub(input logic signed [DW-1:0] a,
                                   input logic signed [DW-1:0] b);
        return sat33({a[DW-1], a} - {b[DW-1], b});
    endfunction

    function automatic logic signed [DW-1:0] deriv(input logic signed [DW-1:0] a);
        return (a > 0) ? ONEV : LEAKV;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) r = CNT_W'(1);
        else if (v > CNT_W'(MAX_NEUR)) r = CNT_W'(MAX_NEUR);
        else r = v;
        return r;
    endfunction

    function automatic logic [LAYER_W-1:0] last_layer(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0) r = 3'd1;
        else if (v > 3'(MAX_LAYER)) r = 3'(MAX_LAYER);
        else r = v;
        return LAYER_W'(r - 3'd1);
    endfunction

endpackage

### src/mlp_backprop_trainer_core.sv
// Top level of the MLP training core: register port, front, back and result queue.
// Depends on mbt_pkg, mbt_fifo, mbt_front and mbt_back.
//
// This core trains a fully connected network of up to four leaky-ReLU layers of up
// to sixteen neurons in signed Q16.16. Items enter through a queue interface: weight,
// bias and sample-input items store one value each; a target item with is_last set
// runs one stochastic gradient step (forward pass, output error, back-propagation,
// weight and bias update) and then delivers one result beat per final-layer neuron,
// in neuron order, with last_output on the final beat and saturated set if any
// arithmetic of the step clipped. All arithmetic goes through a single two-stage
// multiplier and every multiply-accumulate runs to completion before the next
// starts. Results drain one beat at a time, and the sequencer waits while the
// result queue is full. A short command queue in front lets the source keep pushing
// while a step is in progress. Configuration registers sit on the APB port at byte
// addresses 0 (learning_rate), 4 (input_count), 8 (layer_count) and 12 to 24
// (layer0_size to layer3_size); write them only while the core is idle.
// Out-of-range sizes are clamped when a step starts. Reading a weight, bias, input or
// target that was never written yields an undefined value.
module mlp_backprop_trainer_core
    import mbt_pkg::*;
#(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item input queue.
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_opcode,
    input  logic [LAYER_W-1:0]   i_layer_select,
    input  logic [NEUR_W-1:0]    i_neuron_select,
    input  logic [NEUR_W-1:0]    i_weight_select,
    input  logic signed [DW-1:0] i_data_value,
    input  logic                 i_is_last,
    // Result output queue.
    output logic                 empty,
    input  logic                 pop,
    output logic [NEUR_W-1:0]    o_output_neuron,
    output logic signed [DW-1:0] o_output_value,
    output logic                 o_last_output,
    output logic                 o_saturated,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam logic [2:0] REG_LR     = 3'd0;
    localparam logic [2:0] REG_INPUTS = 3'd1;
    localparam logic [2:0] REG_LAYERS = 3'd2;
    localparam logic [2:0] REG_SIZE0  = 3'd3;
    localparam logic [2:0] REG_SIZE1  = 3'd4;
    localparam logic [2:0] REG_SIZE2  = 3'd5;
    localparam logic [2:0] REG_SIZE3  = 3'd6;

    t_cfg r_cfg;
    t_cmd cmd;
    t_res res, res_q;
    logic cmd_valid, cmd_pop, res_push, res_full;
    logic cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // The register file keeps its values across steps; the back part samples it
    // when a step starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate <= 16'd66;
            r_cfg.input_count   <= CNT_W'(2);
            r_cfg.layer_count   <= 3'd4;
            r_cfg.layer_size[0] <= CNT_W'(4);
            r_cfg.layer_size[1] <= CNT_W'(2);
            r_cfg.layer_size[2] <= CNT_W'(9);
            r_cfg.layer_size[3] <= CNT_W'(2);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LR:     r_cfg.learning_rate <= pwdata[15:0];
                REG_INPUTS: r_cfg.input_count   <= pwdata[CNT_W-1:0];
                REG_LAYERS: r_cfg.layer_count   <= pwdata[2:0];
                REG_SIZE0:  r_cfg.layer_size[0] <= pwdata[CNT_W-1:0];
                REG_SIZE1:  r_cfg.layer_size[1] <= pwdata[CNT_W-1:0];
                REG_SIZE2:  r_cfg.layer_size[2] <= pwdata[CNT_W-1:0];
                REG_SIZE3:  r_cfg.layer_size[3] <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LR:     prdata = {16'b0, r_cfg.learning_rate};
            REG_INPUTS: prdata = {27'b0, r_cfg.input_count};
            REG_LAYERS: prdata = {29'b0, r_cfg.layer_count};
            REG_SIZE0:  prdata = {27'b0, r_cfg.layer_size[0]};
            REG_SIZE1:  prdata = {27'b0, r_cfg.layer_size[1]};
            REG_SIZE2:  prdata = {27'b0, r_cfg.layer_size[2]};
            REG_SIZE3:  prdata = {27'b0, r_cfg.layer_size[3]};
            default:    prdata = '0;
        endcase
    end

    // Front part: classifies items and buffers them ahead of the engine.
    mbt_front #(.DEPTH(IN_DEPTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_opcode       (i_opcode),
        .i_layer_select (i_layer_select),
        .i_neuron_select(i_neuron_select),
        .i_weight_select(i_weight_select),
        .i_data_value   (i_data_value),
        .i_is_last      (i_is_last),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_pop      (cmd_pop)
    );

    // Back part: stores and the training sequencer.
    mbt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_cmd_valid(cmd_valid),
        .o_cmd_pop  (cmd_pop),
        .o_res      (res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    // Result queue: the sequencer stalls on it when the consumer falls behind.
    mbt_fifo #(.WIDTH($bits(t_res)), .DEPTH(OUT_DEPTH)) u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_q),
        .o_empty(empty)
    );

    assign o_output_neuron = res_q.neuron;
    assign o_output_value  = res_q.value;
    assign o_last_output   = res_q.last;
    assign o_saturated     = res_q.sat;

    // The engine must never push a beat into a full result queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full) else $error("result pushed into full queue");

    // Commands are taken only when the front queue holds one.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid) else $error("command popped from empty queue");

    // A pushed beat is visible to the consumer on the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |=> !empty) else $error("pushed result not visible");

endmodule

### src/mbt_fifo.sv
// Small first-in first-out queue of flat words.
// Used for the command queue and the result queue; depends on nothing.
module mbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### src/mbt_fxmul.sv
// Two-stage signed fixed-point multiplier with rounding and saturation.
// Depends on mbt_pkg.
module mbt_fxmul
    import mbt_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_p,
    output logic                 o_sat
);
    logic [DW-1:0]        ua, ub;
    logic [2*DW-1:0]      r_prod;
    logic                 r_neg;
    logic [2*DW-1:0]      rnd;
    logic [47:0]          q, lim;
    logic                 sat;
    logic [DW-1:0]        mag;
    logic signed [DW-1:0] r_p;
    logic                 r_sat;

    assign ua  = i_a[DW-1] ? (~i_a + DW'(1)) : i_a;
    assign ub  = i_b[DW-1] ? (~i_b + DW'(1)) : i_b;
    assign rnd = r_prod + 64'd32768;
    assign q   = rnd[63:16];
    assign lim = r_neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    assign sat = (q > lim);
    assign mag = sat ? lim[DW-1:0] : q[DW-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= ua * ub;
        r_neg  <= i_a[DW-1] ^ i_b[DW-1];
        r_p    <= r_neg ? (~mag + DW'(1)) : mag;
        r_sat  <= sat;
    end

    assign o_p   = r_p;
    assign o_sat = r_sat;

endmodule

### src/mbt_front.sv
// Front part: classifies incoming items into commands and queues them.
// Depends on mbt_pkg and mbt_fifo.
module mbt_front
    import mbt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_opcode,
    input  logic [LAYER_W-1:0]   i_layer_select,
    input  logic [NEUR_W-1:0]    i_neuron_select,
    input  logic [NEUR_W-1:0]    i_weight_select,
    input  logic signed [DW-1:0] i_data_value,
    input  logic                 i_is_last,
    output t_cmd                 o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_pop
);
    t_cmd cmd;
    logic q_empty;

    // Only the last target starts a training step.
    always_comb begin
        cmd.op     = i_opcode;
        cmd.step   = (i_opcode == OP_TARGET) && i_is_last;
        cmd.layer  = i_layer_select;
        cmd.neuron = i_neuron_select;
        cmd.windex = i_weight_select;
        cmd.data   = i_data_value;
    end

    mbt_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(DEPTH)) u_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (cmd),
        .o_full (o_full),
        .i_pop  (i_cmd_pop),
        .o_data (o_cmd),
        .o_empty(q_empty)
    );

    assign o_cmd_valid = !q_empty;

endmodule

### src/mbt_back.sv
// Back part: parameter stores and the training sequencer around one multiplier.
// Depends on mbt_pkg and mbt_fxmul.
module mbt_back
    import mbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    output t_res o_res,
    output logic o_res_push,
    input  logic i_res_full
);
    typedef enum logic [3:0] {
        S_IDLE, S_FWD, S_FBIAS, S_OERR, S_BP, S_BPD, S_UG, S_UW, S_UB, S_OUT
    } t_state;

    localparam int WA = 2 * NEUR_W + LAYER_W;
    localparam int NA = NEUR_W + LAYER_W;

    t_state r_state;
    logic [2:0]                 r_ph;
    logic [LAYER_W-1:0]         r_l, r_last;
    logic [NEUR_W-1:0]          r_i, r_j;
    logic signed [DW-1:0]       r_acc, r_e, r_g;
    logic                       r_sat;
    logic [CNT_W-1:0]           r_nin;
    logic [3:0][CNT_W-1:0]      r_sz;
    logic [15:0]                r_lr;

    logic signed [DW-1:0] wt_mem   [1 << WA];
    logic signed [DW-1:0] bias_mem [1 << NA];
    logic signed [DW-1:0] act_mem  [1 << NA];
    logic signed [DW-1:0] err_mem  [1 << NA];
    logic signed [DW-1:0] in_mem   [MAX_NEUR];
    logic signed [DW-1:0] tgt_mem  [MAX_NEUR];

    logic signed [DW-1:0] wt_rd, bias_rd, act_rd, err_rd, in_rd, tgt_rd;
    logic [WA-1:0]        wt_ra, wt_wa;
    logic [NA-1:0]        act_ra, err_ra, bias_ra, bias_wa, act_wa, err_wa;
    logic [NEUR_W-1:0]    in_ra;
    logic                 wt_we, bias_we, act_we, err_we, in_we, tgt_we;
    logic signed [DW-1:0] wt_wd, bias_wd, act_wd, err_wd;

    logic [LAYER_W-1:0]   lp1, lm1;
    logic [CNT_W-1:0]     k, i_nx, j_nx;
    logic signed [DW-1:0] x, m_a, m_b, mul_p;
    logic                 mul_sat;
    t_sres                add_p, add_b, sub_e, dbl_e, wsub, bsub;

    assign lp1  = r_l + LAYER_W'(1);
    assign lm1  = r_l - LAYER_W'(1);
    assign k    = (r_l == '0) ? r_nin : r_sz[lm1];
    assign i_nx = {1'b0, r_i} + CNT_W'(1);
    assign j_nx = {1'b0, r_j} + CNT_W'(1);
    assign x    = (r_l == '0) ? in_rd : act_rd;

    assign add_p = sadd(r_acc, mul_p);
    assign add_b = sadd(r_acc, bias_rd);
    assign sub_e = ssub(act_rd, tgt_rd);
    assign dbl_e = sadd(r_e, r_e);
    assign wsub  = ssub(wt_rd, mul_p);
    assign bsub  = ssub(bias_rd, r_g);

    // Read addresses depend on the state and loop counters only, so read data
    // holds steady through all phases of one operation.
    always_comb begin
        wt_ra   = {r_l, r_j, r_i};
        act_ra  = {lm1, r_i};
        err_ra  = {lp1, r_j};
        bias_ra = {r_l, r_j};
        in_ra   = r_i;
        case (r_state)
            S_BP:         wt_ra = {lp1, r_j, r_i};
            S_UW: begin
                wt_ra  = {r_l, r_i, r_j};
                act_ra = {lm1, r_j};
                in_ra  = r_j;
            end
            S_OERR, S_OUT: act_ra = {r_last, r_j};
            S_BPD:        act_ra = {r_l, r_i};
            S_UG:         err_ra = {r_l, r_i};
            S_UB:         bias_ra = {r_l, r_i};
            default:      ;
        endcase
    end

    always_comb begin
        m_a = wt_rd;
        m_b = x;
        case (r_state)
            S_FBIAS: begin m_a = r_acc; m_b = LEAKV; end
            S_OERR:  begin m_a = r_e; m_b = deriv(act_rd); end
            S_BP:    begin m_a = err_rd; m_b = wt_rd; end
            S_BPD:   begin m_a = r_acc; m_b = deriv(act_rd); end
            S_UG:    begin m_a = {16'b0, r_lr}; m_b = err_rd; end
            S_UW:    begin m_a = r_g; m_b = x; end
            default: ;
        endcase
    end

    mbt_fxmul u_mul (
        .i_clk(i_clk),
        .i_a  (m_a),
        .i_b  (m_b),
        .o_p  (mul_p),
        .o_sat(mul_sat)
    );

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        wt_we   = 1'b0;
        wt_wa   = wt_ra;
        wt_wd   = wsub.val;
        bias_we = 1'b0;
        bias_wa = bias_ra;
        bias_wd = bsub.val;
        in_we   = o_cmd_pop && (i_cmd.op == OP_INPUT);
        tgt_we  = o_cmd_pop && (i_cmd.op == OP_TARGET);
        act_we  = (r_state == S_FBIAS) && (r_ph == 3'd4);
        act_wa  = {r_l, r_j};
        act_wd  = (r_acc > 0) ? r_acc : mul_p;
        err_we  = 1'b0;
        err_wa  = {r_l, r_i};
        err_wd  = mul_p;
        if (o_cmd_pop && i_cmd.op == OP_WEIGHT) begin
            wt_we = 1'b1;
            wt_wa = {i_cmd.layer, i_cmd.neuron, i_cmd.windex};
            wt_wd = i_cmd.data;
        end else if (r_state == S_UW && r_ph == 3'd3) begin
            wt_we = 1'b1;
        end
        if (o_cmd_pop && i_cmd.op == OP_BIAS) begin
            bias_we = 1'b1;
            bias_wa = {i_cmd.layer, i_cmd.neuron};
            bias_wd = i_cmd.data;
        end else if (r_state == S_UB && r_ph == 3'd1) begin
            bias_we = 1'b1;
        end
        if (r_state == S_OERR && r_ph == 3'd5) begin
            err_we = 1'b1;
            err_wa = {r_last, r_j};
        end else if (r_state == S_BPD && r_ph == 3'd3) begin
            err_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) wt_mem[wt_wa] <= wt_wd;
        wt_rd <= wt_mem[wt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bias_we) bias_mem[bias_wa] <= bias_wd;
        bias_rd <= bias_mem[bias_ra];
    end

    always_ff @(posedge i_clk) begin
        if (act_we) act_mem[act_wa] <= act_wd;
        act_rd <= act_mem[act_ra];
    end

    always_ff @(posedge i_clk) begin
        if (err_we) err_mem[err_wa] <= err_wd;
        err_rd <= err_mem[err_ra];
    end

    always_ff @(posedge i_clk) begin
        if (in_we) in_mem[i_cmd.windex] <= i_cmd.data;
        in_rd <= in_mem[in_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) tgt_mem[i_cmd.neuron] <= i_cmd.data;
        tgt_rd <= tgt_mem[r_j];
    end

    assign o_res_push  = (r_state == S_OUT) && (r_ph == 3'd1) && !i_res_full;
    assign o_res.neuron = r_j;
    assign o_res.value  = act_rd;
    assign o_res.last   = (j_nx == r_sz[r_last]);
    assign o_res.sat    = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && i_cmd.step) begin
                        r_sat   <= 1'b0;
                        r_lr    <= i_cfg.learning_rate;
                        r_nin   <= clamp_size(i_cfg.input_count);
                        r_last  <= last_layer(i_cfg.layer_count);
                        for (int s = 0; s < 4; s++) begin
                            r_sz[s] <= clamp_size(i_cfg.layer_size[s]);
                        end
                        r_l     <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_ph    <= '0;
                        r_state <= S_FWD;
                    end
                end
                S_FWD: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd3) begin
                        r_acc <= add_p.val;
                        r_sat <= r_sat | add_p.sat | mul_sat;
                        r_ph  <= '0;
                        if (i_nx < k) r_i <= r_i + NEUR_W'(1);
                        else r_state <= S_FBIAS;
                    end
                end
                S_FBIAS: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd1) begin
                        r_acc <= add_b.val;
                        r_sat <= r_sat | add_b.sat;
                    end
                    if (r_ph == 3'd4) begin
                        if (r_acc <= 0) r_sat <= r_sat | mul_sat;
                        r_ph  <= '0;
                        r_i   <= '0;
                        r_acc <= '0;
                        if (j_nx < r_sz[r_l]) begin
                            r_j     <= r_j + NEUR_W'(1);
                            r_state <= S_FWD;
                        end else if (r_l == r_last) begin
                            r_j     <= '0;
                            r_state <= S_OERR;
                        end else begin
                            r_l     <= lp1;
                            r_j     <= '0;
                            r_state <= S_FWD;
                        end
                    end
                end
                S_OERR: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd1) begin
                        r_e   <= sub_e.val;
                        r_sat <= r_sat | sub_e.sat;
                    end
                    if (r_ph == 3'd2) begin
                        r_e   <= dbl_e.val;
                        r_sat <= r_sat | dbl_e.sat;
                    end
                    if (r_ph == 3'd5) begin
                        r_sat <= r_sat | mul_sat;
                        r_ph  <= '0;
                        if (j_nx < r_sz[r_last]) begin
                            r_j <= r_j + NEUR_W'(1);
                        end else begin
                            r_i   <= '0;
                            r_j   <= '0;
                            r_acc <= '0;
                            if (r_last == '0) begin
                                r_l     <= '0;
                                r_state <= S_UG;
                            end else begin
                                r_l     <= r_last - LAYER_W'(1);
                                r_state <= S_BP;
                            end
                        end
                    end
                end
                S_BP: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd3) begin
                        r_acc <= add_p.val;
                        r_sat <= r_sat | add_p.sat | mul_sat;
                        r_ph  <= '0;
                        if (j_nx < r_sz[lp1]) r_j <= r_j + NEUR_W'(1);
                        else r_state <= S_BPD;
                    end
                end
                S_BPD: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd3) begin
                        r_sat <= r_sat | mul_sat;
                        r_ph  <= '0;
                        r_j   <= '0;
                        r_acc <= '0;
                        if (i_nx < r_sz[r_l]) begin
                            r_i     <= r_i + NEUR_W'(1);
                            r_state <= S_BP;
                        end else if (r_l == '0) begin
                            r_i     <= '0;
                            r_state <= S_UG;
                        end else begin
                            r_i     <= '0;
                            r_l     <= lm1;
                            r_state <= S_BP;
                        end
                    end
                end
                S_UG: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd3) begin
                        r_g     <= mul_p;
                        r_sat   <= r_sat | mul_sat;
                        r_ph    <= '0;
                        r_j     <= '0;
                        r_state <= S_UW;
                    end
                end
                S_UW: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd3) begin
                        r_sat <= r_sat | mul_sat | wsub.sat;
                        r_ph  <= '0;
                        if (j_nx < k) r_j <= r_j + NEUR_W'(1);
                        else r_state <= S_UB;
                    end
                end
                S_UB: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd1) begin
                        r_sat <= r_sat | bsub.sat;
                        r_ph  <= '0;
                        if (i_nx < r_sz[r_l]) begin
                            r_i     <= r_i + NEUR_W'(1);
                            r_state <= S_UG;
                        end else if (r_l == r_last) begin
                            r_j     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_l     <= lp1;
                            r_i     <= '0;
                            r_state <= S_UG;
                        end
                    end
                end
                S_OUT: begin
                    if (r_ph == 3'd0) begin
                        r_ph <= 3'd1;
                    end else if (o_res_push) begin
                        r_ph <= '0;
                        if (o_res.last) r_state <= S_IDLE;
                        else r_j <= r_j + NEUR_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### dv/mbt_tb_pkg.sv
// Register indexes and the training scoreboard of the MLP trainer testbench.
// The scoreboard predicts every result beat from the accepted items.
// Depends on mbt_pkg for the item and result types.
package mbt_tb_pkg;
    import mbt_pkg::*;

    typedef enum int {
        REG_LEARN_RATE, REG_INPUT_COUNT, REG_LAYER_COUNT,
        REG_LAYER0_SIZE, REG_LAYER1_SIZE, REG_LAYER2_SIZE, REG_LAYER3_SIZE
    } t_reg_index;

    localparam longint FX_MAX  = 64'sd2147483647;
    localparam longint FX_MIN  = -64'sd2147483648;
    localparam longint FX_ONE  = 64'sd65536;
    localparam longint FX_LEAK = 64'sd655;

    class train_scoreboard;
        longint     weight_mem [1024];
        longint     bias_mem   [64];
        longint     input_mem  [16];
        longint     target_mem [16];
        longint     act_mem    [64];
        longint     err_mem    [64];
        bit [15:0]  learn_rate  = 16'd66;
        bit [4:0]   input_count = 5'd2;
        bit [2:0]   layer_count = 3'd4;
        bit [4:0]   size_reg [4] = '{5'd4, 5'd2, 5'd9, 5'd2};
        bit         clipped;
        t_res       pending_beats [$];
        int         mismatches;

        function void set_reg(t_reg_index idx, bit [31:0] v);
            case (idx)
                REG_LEARN_RATE:  learn_rate = v[15:0];
                REG_INPUT_COUNT: input_count = v[4:0];
                REG_LAYER_COUNT: layer_count = v[2:0];
                default:         size_reg[int'(idx) - int'(REG_LAYER0_SIZE)] = v[4:0];
            endcase
        endfunction

        function int layers_used();
            return layer_count == 0 ? 1 : (layer_count > 4 ? 4 : int'(layer_count));
        endfunction

        function int inputs_used();
            return input_count == 0 ? 1 : (input_count > 16 ? 16 : int'(input_count));
        endfunction

        function int size_used(int l);
            return size_reg[l] == 0 ? 1 : (size_reg[l] > 16 ? 16 : int'(size_reg[l]));
        endfunction

        function longint clip(longint v);
            if (v > FX_MAX) begin clipped = 1; return FX_MAX; end
            if (v < FX_MIN) begin clipped = 1; return FX_MIN; end
            return v;
        endfunction

        // Exact product, magnitude rounded half away from zero, then saturated.
        function longint scaled_mul(longint a, longint b);
            bit                neg;
            longint unsigned   mag, q, lim;
            neg = (a < 0) != (b < 0);
            mag = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
            q   = (mag + 64'd32768) >> 16;
            lim = neg ? 64'd2147483648 : 64'd2147483647;
            if (q > lim) begin
                clipped = 1;
                q = lim;
            end
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function longint slope(longint a);
            return a > 0 ? FX_ONE : FX_LEAK;
        endfunction

        function void train_step();
            int     nl, fan_in, last;
            int     sz [4];
            longint acc, x, y, e, g;
            nl = layers_used();
            for (int l = 0; l < 4; l++) sz[l] = size_used(l);
            foreach (act_mem[i]) begin act_mem[i] = 0; err_mem[i] = 0; end
            clipped = 0;
            for (int l = 0; l < nl; l++) begin
                fan_in = l == 0 ? inputs_used() : sz[l-1];
                for (int j = 0; j < sz[l]; j++) begin
                    acc = 0;
                    for (int i = 0; i < fan_in; i++) begin
                        x = l == 0 ? input_mem[i] : act_mem[(l-1)*16 + i];
                        acc = clip(acc + scaled_mul(weight_mem[(l*16 + j)*16 + i], x));
                    end
                    acc = clip(acc + bias_mem[l*16 + j]);
                    act_mem[l*16 + j] = acc > 0 ? acc : scaled_mul(acc, FX_LEAK);
                end
            end
            last = nl - 1;
            for (int j = 0; j < sz[last]; j++) begin
                y = act_mem[last*16 + j];
                e = clip(y - target_mem[j]);
                e = clip(e + e);
                err_mem[last*16 + j] = scaled_mul(e, slope(y));
            end
            for (int l = last - 1; l >= 0; l--) begin
                for (int i = 0; i < sz[l]; i++) begin
                    acc = 0;
                    for (int j = 0; j < sz[l+1]; j++)
                        acc = clip(acc + scaled_mul(err_mem[(l+1)*16 + j],
                                                    weight_mem[((l+1)*16 + j)*16 + i]));
                    err_mem[l*16 + i] = scaled_mul(acc, slope(act_mem[l*16 + i]));
                end
            end
            for (int l = 0; l < nl; l++) begin
                fan_in = l == 0 ? inputs_used() : sz[l-1];
                for (int i = 0; i < sz[l]; i++) begin
                    g = scaled_mul(longint'(learn_rate), err_mem[l*16 + i]);
                    for (int j = 0; j < fan_in; j++) begin
                        x = l == 0 ? input_mem[j] : act_mem[(l-1)*16 + j];
                        weight_mem[(l*16 + i)*16 + j] =
                            clip(weight_mem[(l*16 + i)*16 + j] - scaled_mul(g, x));
                    end
                    bias_mem[l*16 + i] = clip(bias_mem[l*16 + i] - g);
                end
            end
            for (int j = 0; j < sz[last]; j++) begin
                t_res r;
                r.neuron = NEUR_W'(j);
                r.value  = DW'(act_mem[last*16 + j]);
                r.last   = (j + 1 == sz[last]);
                r.sat    = clipped;
                pending_beats.push_back(r);
            end
        endfunction

        function void note_item(t_cmd c);
            case (c.op)
                OP_WEIGHT: weight_mem[{c.layer, c.neuron, c.windex}] = c.data;
                OP_BIAS:   bias_mem[{c.layer, c.neuron}] = c.data;
                OP_INPUT:  input_mem[c.windex] = c.data;
                default: begin
                    target_mem[c.neuron] = c.data;
                    if (c.step) train_step();
                end
            endcase
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: neuron %0d value %0d",
                             got.neuron, got.value);
                return;
            end
            want = pending_beats.pop_front();
            if (got.neuron !== want.neuron || got.value !== want.value ||
                got.last !== want.last || got.sat !== want.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected n=%0d v=%0d last=%0b sat=%0b, got n=%0d v=%0d last=%0b sat=%0b",
                             want.neuron, want.value, want.last, want.sat,
                             got.neuron, got.value, got.last, got.sat);
            end
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction
    endclass

endpackage

### dv/testbench.sv
// Top-level testbench of the MLP training core: drives items, config and result pops.
// Depends on mbt_pkg, mbt_tb_pkg and the mlp_backprop_trainer_core RTL.
module testbench;
    import mbt_pkg::*;
    import mbt_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A step on the largest network built here runs with nothing accepted, and the long
    // receiver hold-off comes on top of it, so the watchdog limit allows many times
    // their sum.
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEM_COUNT   = 350;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [1:0]           i_opcode = '0;
    logic [LAYER_W-1:0]   i_layer_select = '0;
    logic [NEUR_W-1:0]    i_neuron_select = '0;
    logic [NEUR_W-1:0]    i_weight_select = '0;
    logic signed [DW-1:0] i_data_value = '0;
    logic                 i_is_last = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [NEUR_W-1:0]    o_output_neuron;
    logic signed [DW-1:0] o_output_value;
    logic                 o_last_output;
    logic                 o_saturated;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [4:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    mlp_backprop_trainer_core u_top (.*);

    always #5 i_clk = ~i_clk;

    train_scoreboard sb = new();

    // Tracks which stored entries the stimulus has written, so that a step never
    // reads an entry whose value is still undefined.
    bit weight_set [1024];
    bit bias_set   [64];
    bit input_set  [16];
    bit target_set [16];

    bit no_idle = 1'b0;
    bit long_hold = 1'b0;
    int items_sent = 0;
    int stall_cycles = 0;

    // The watchdog restarts whenever either queue moves a beat.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Configuration writes: a setup phase, then the access phase in which pready is high.
    // psel stays high across a burst of writes and is dropped by the caller.
    task automatic apb_write(t_reg_index idx, bit [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * int'(idx));
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic program_net(bit [15:0] lr, bit [4:0] n_in, bit [2:0] n_layers,
                               bit [4:0] s0, bit [4:0] s1, bit [4:0] s2, bit [4:0] s3);
        apb_write(REG_LEARN_RATE, lr);
        apb_write(REG_INPUT_COUNT, n_in);
        apb_write(REG_LAYER_COUNT, n_layers);
        apb_write(REG_LAYER0_SIZE, s0);
        apb_write(REG_LAYER1_SIZE, s1);
        apb_write(REG_LAYER2_SIZE, s2);
        apb_write(REG_LAYER3_SIZE, s3);
        psel <= 1'b0;
    endtask

    // Sender pause: every expected beat must come back before the network changes.
    // Trailing load items cause no result, so a drain wait follows for them.
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(t_cmd c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_opcode        <= c.op;
        i_layer_select  <= c.layer;
        i_neuron_select <= c.neuron;
        i_weight_select <= c.windex;
        i_data_value    <= c.data;
        i_is_last       <= c.step;
        do @(posedge i_clk); while (full);
        sb.note_item(c);
    endtask

    // Values are mostly small so that the network does real work; the rest hit the
    // extremes and random full-width patterns that drive saturation.
    function automatic logic signed [DW-1:0] pick_value(bit directed);
        logic signed [DW-1:0] corner [6] = '{MAXV, MINV, 32'sd0, 32'sd1, -32'sd1, ONEV};
        int r;
        if (directed) return corner[$urandom_range(0, 5)];
        r = $urandom_range(0, 9);
        if (r < 5) return DW'($signed($urandom_range(0, 262144)) - 131072);
        if (r < 8) return DW'($signed($urandom_range(0, 2097152)) - 1048576);
        if (r < 9) return DW'($urandom());
        return corner[$urandom_range(0, 5)];
    endfunction

    function automatic t_cmd make_cmd(logic [1:0] op, int l, int n, int w,
                                      logic signed [DW-1:0] v, bit step);
        t_cmd c;
        c.op = op; c.layer = LAYER_W'(l); c.neuron = NEUR_W'(n);
        c.windex = NEUR_W'(w); c.data = v; c.step = step;
        case (op)
            OP_WEIGHT: weight_set[(l*16 + n)*16 + w] = 1'b1;
            OP_BIAS:   bias_set[l*16 + n] = 1'b1;
            OP_INPUT:  input_set[w] = 1'b1;
            default:   target_set[n] = 1'b1;
        endcase
        return c;
    endfunction

    // One training sample: loads for every entry the step will read that is still
    // unset plus some rewrites, a little noise, and the target that starts the step.
    // Now and then the closing target is left out, so a sample is abandoned.
    task automatic run_sample(bit directed);
        t_cmd q [$];
        t_cmd tmp;
        int   nl, fan_in, last_sz, k, fin_n;
        bit   redo;
        nl = sb.layers_used();
        last_sz = sb.size_used(nl - 1);
        for (int l = 0; l < nl; l++) begin
            fan_in = l == 0 ? sb.inputs_used() : sb.size_used(l - 1);
            for (int j = 0; j < sb.size_used(l); j++) begin
                for (int i = 0; i < fan_in; i++) begin
                    redo = directed || $urandom_range(0, 3) == 0;
                    if (!weight_set[(l*16 + j)*16 + i] || redo)
                        q.push_back(make_cmd(OP_WEIGHT, l, j, i, pick_value(directed),
                                             1'($urandom())));
                end
                if (!bias_set[l*16 + j] || directed || $urandom_range(0, 3) == 0)
                    q.push_back(make_cmd(OP_BIAS, l, j, $urandom_range(0, 15),
                                         pick_value(directed), 1'($urandom())));
            end
        end
        for (int i = 0; i < sb.inputs_used(); i++)
            if (!input_set[i] || directed || $urandom_range(0, 1) == 0)
                q.push_back(make_cmd(OP_INPUT, $urandom_range(0, 3), $urandom_range(0, 15),
                                     i, pick_value(directed), 1'($urandom())));
        fin_n = $urandom_range(0, 15);
        for (int j = 0; j < last_sz; j++)
            if (j != fin_n && (!target_set[j] || directed || $urandom_range(0, 1) == 0))
                q.push_back(make_cmd(OP_TARGET, $urandom_range(0, 3), j,
                                     $urandom_range(0, 15), pick_value(directed), 1'b0));
        // Noise: loads anywhere in the stores and targets that do not start a step.
        repeat ($urandom_range(0, 3)) begin
            logic [1:0] op;
            op = 2'($urandom_range(0, 3));
            q.push_back(make_cmd(op, $urandom_range(0, 3), $urandom_range(0, 15),
                                 $urandom_range(0, 15), pick_value(0),
                                 op == OP_TARGET ? 1'b0 : 1'($urandom())));
        end
        for (int i = q.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = q[i]; q[i] = q[k]; q[k] = tmp;
        end
        if (directed || $urandom_range(0, 15) != 0)
            q.push_back(make_cmd(OP_TARGET, $urandom_range(0, 3), fin_n,
                                 $urandom_range(0, 15), pick_value(directed), 1'b1));
        foreach (q[i]) begin
            send_item(q[i]);
            items_sent++;
        end
    endtask

    // Result side: random pop gaps, and one long hold-off while the sender keeps
    // offering items, so that both queues fill and the input stalls.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (long_hold) begin
                gap = 600;
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result('{neuron: o_output_neuron, value: o_output_value,
                              last: o_last_output, sat: o_saturated});
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings: extreme values in every field,
        // every operation, and is_last on items that ignore it.
        run_sample(1);
        wait_idle();

        // Widest output layer with the full learning rate: sixteen beats per step.
        program_net(16'hFFFF, 5'd4, 3'd1, 5'd16, 5'd16, 5'd16, 5'd16);
        run_sample(0);
        wait_idle();

        // Smallest network and a zero learning rate, so weights never change. The
        // receiver holds off for a long stretch here while short steps keep coming.
        program_net(16'h0000, 5'd1, 3'd1, 5'd1, 5'd1, 5'd1, 5'd1);
        long_hold = 1'b1;
        repeat (8) run_sample(0);
        wait_idle();

        // Out-of-range register values, which are clamped when a step starts.
        program_net(16'(($urandom())), 5'd0, 3'd0, 5'd0, 5'd31, 5'd17, 5'd20);
        repeat (3) run_sample(0);
        wait_idle();
        program_net(16'(($urandom())), 5'd31, 3'd7, 5'd1, 5'd0, 5'd31, 5'd1);
        run_sample(0);
        wait_idle();

        // Random small networks; some phases run with no idling on either side.
        while (items_sent < ITEM_COUNT) begin
            program_net(16'($urandom()), 5'($urandom_range(0, 6)), 3'($urandom_range(0, 5)),
                        5'($urandom_range(0, 6)), 5'($urandom_range(0, 6)),
                        5'($urandom_range(0, 6)), 5'($urandom_range(0, 6)));
            no_idle = $urandom_range(0, 3) == 0;
            repeat ($urandom_range(2, 5)) run_sample(0);
            wait_idle();
        end

        wait_idle();
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
